[rtl/core/plia_pkg.sv]
package plia_pkg;

    localparam int unsigned IndexWidth = 32;
    localparam int unsigned CountWidth = 32;
    localparam int unsigned ByteWidth  = 8;

    // configuration register indexes
    localparam logic [1:0] REG_STRIP_MODE  = 2'd0;
    localparam logic [1:0] REG_COUNT_WIDTH = 2'd1;
    localparam logic [1:0] REG_INDEX_WIDTH = 2'd2;
    localparam logic [1:0] REG_ENTRY_TOTAL = 2'd3;

    // byte width codes
    localparam logic [1:0] WCODE_ONE  = 2'd0;
    localparam logic [1:0] WCODE_TWO  = 2'd1;
    localparam logic [1:0] WCODE_FOUR = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_FACE = 2'd0;
    localparam logic [1:0] KIND_TRI  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    typedef struct packed {
        logic                    strip_mode;
        logic [1:0]              count_width_code;
        logic [1:0]              index_width_code;
        logic                    entry_load;
        logic [CountWidth-1:0]   entry_value;
    } cfg_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IndexWidth-1:0]   first;
        logic [IndexWidth-1:0]   second;
        logic [IndexWidth-1:0]   third;
        logic                    entry_end;
        logic                    element_done;
    } result_t;

    // number of bytes for a width code; code three counts as four bytes
    function automatic logic [2:0] width_bytes(input logic [1:0] code);
        logic [2:0] w;
        unique case (code)
            WCODE_ONE: w = 3'd1;
            WCODE_TWO: w = 3'd2;
            default:   w = 3'd4;
        endcase
        return w;
    endfunction

    // restart marker at a width code
    function automatic logic [IndexWidth-1:0] all_ones(input logic [1:0] code);
        logic [IndexWidth-1:0] v;
        unique case (code)
            WCODE_ONE: v = IndexWidth'(8'hFF);
            WCODE_TWO: v = IndexWidth'(16'hFFFF);
            default:   v = '1;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/plia_cfg_regs.sv]
module plia_cfg_regs
    import plia_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CountWidth-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic       strip_mode_reg;
    logic [1:0] count_width_reg;
    logic [1:0] index_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_mode_reg  <= 1'b0;
            count_width_reg <= WCODE_ONE;
            index_width_reg <= WCODE_FOUR;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STRIP_MODE:  strip_mode_reg  <= cfg_data[0];
                REG_COUNT_WIDTH: count_width_reg <= cfg_data[1:0];
                REG_INDEX_WIDTH: index_width_reg <= cfg_data[1:0];
                default:         ; // entry total goes straight to the parser
            endcase
        end
    end

    always_comb
    begin
        cfg.strip_mode       = strip_mode_reg;
        cfg.count_width_code = count_width_reg;
        cfg.index_width_code = index_width_reg;
        cfg.entry_load       = cfg_write && (cfg_index == REG_ENTRY_TOTAL);
        cfg.entry_value      = cfg_data;
    end

endmodule

[rtl/core/plia_parse.sv]
module plia_parse
    import plia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 step,
    input  logic [ByteWidth-1:0] byte_in,
    output logic                 res_valid,
    output result_t              res
);

    logic                  reading_count_reg, reading_count_next;
    logic [1:0]            byte_pos_reg, byte_pos_next;
    logic [IndexWidth-1:0] value_reg, value_next;
    logic [CountWidth-1:0] indices_left_reg, indices_left_next;
    logic [CountWidth-1:0] entries_left_reg, entries_left_next;
    logic                  older_valid_reg, older_valid_next;
    logic [IndexWidth-1:0] older_reg, older_next;
    logic                  newer_valid_reg, newer_valid_next;
    logic [IndexWidth-1:0] newer_reg, newer_next;

    logic [1:0]            wcode;
    logic [IndexWidth-1:0] assembled;
    logic [1:0]            pos_inc;
    logic                  complete;
    logic                  ended;
    logic                  have_prim;
    logic [CountWidth-1:0] idx_dec;
    logic [CountWidth-1:0] ent_dec;

    always_comb
    begin
        wcode     = reading_count_reg ? cfg.count_width_code : cfg.index_width_code;
        assembled = value_reg
                  | (IndexWidth'(byte_in) << {byte_pos_reg, 3'b000});
        pos_inc   = byte_pos_reg + 2'd1;
        complete  = (pos_inc == 2'd0) || ({1'b0, pos_inc} >= width_bytes(wcode));
        idx_dec   = indices_left_reg - CountWidth'(1);
        ent_dec   = entries_left_reg - CountWidth'(1);

        reading_count_next = reading_count_reg;
        byte_pos_next      = byte_pos_reg;
        value_next         = value_reg;
        indices_left_next  = indices_left_reg;
        entries_left_next  = entries_left_reg;
        older_valid_next   = older_valid_reg;
        older_next         = older_reg;
        newer_valid_next   = newer_valid_reg;
        newer_next         = newer_reg;

        ended     = 1'b0;
        have_prim = 1'b0;
        res       = '0;
        res_valid = 1'b0;

        if (cfg.entry_load)
        begin
            entries_left_next  = cfg.entry_value;
            reading_count_next = 1'b1;
            byte_pos_next      = 2'd0;
            value_next         = '0;
            indices_left_next  = '0;
            older_valid_next   = 1'b0;
            older_next         = '0;
            newer_valid_next   = 1'b0;
            newer_next         = '0;
        end
        else if (step && (entries_left_reg != '0))
        begin
            if (!complete)
            begin
                value_next    = assembled;
                byte_pos_next = pos_inc;
            end
            else
            begin
                value_next    = '0;
                byte_pos_next = 2'd0;
                if (reading_count_reg)
                begin
                    indices_left_next = assembled;
                    older_valid_next  = 1'b0;
                    older_next        = '0;
                    newer_valid_next  = 1'b0;
                    newer_next        = '0;
                    if (assembled == '0)
                        ended = 1'b1;
                    else
                        reading_count_next = 1'b0;
                end
                else
                begin
                    priority if (!cfg.strip_mode)
                    begin
                        have_prim = 1'b1;
                        res.kind  = KIND_FACE;
                        res.first = assembled;
                    end
                    else if (assembled == all_ones(wcode))
                    begin
                        // restart: drop the strip window
                        older_valid_next = 1'b0;
                        older_next       = '0;
                        newer_valid_next = 1'b0;
                        newer_next       = '0;
                    end
                    else if (!older_valid_reg)
                    begin
                        older_valid_next = 1'b1;
                        older_next       = assembled;
                    end
                    else if (!newer_valid_reg)
                    begin
                        newer_valid_next = 1'b1;
                        newer_next       = assembled;
                    end
                    else
                    begin
                        have_prim  = 1'b1;
                        res.kind   = KIND_TRI;
                        res.first  = older_reg;
                        res.second = newer_reg;
                        res.third  = assembled;
                        older_next = newer_reg;
                        newer_next = assembled;
                    end
                    indices_left_next = idx_dec;
                    if (idx_dec == '0)
                        ended = 1'b1;
                end

                if (ended)
                begin
                    reading_count_next = 1'b1;
                    entries_left_next  = ent_dec;
                    res.entry_end      = 1'b1;
                    res.element_done   = (ent_dec == '0);
                end

                if (!have_prim && res.element_done)
                    res.kind = KIND_DONE;
                res_valid = have_prim || res.element_done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_count_reg <= 1'b1;
            byte_pos_reg      <= 2'd0;
            value_reg         <= '0;
            indices_left_reg  <= '0;
            entries_left_reg  <= '0;
            older_valid_reg   <= 1'b0;
            older_reg         <= '0;
            newer_valid_reg   <= 1'b0;
            newer_reg         <= '0;
        end
        else
        begin
            reading_count_reg <= reading_count_next;
            byte_pos_reg      <= byte_pos_next;
            value_reg         <= value_next;
            indices_left_reg  <= indices_left_next;
            entries_left_reg  <= entries_left_next;
            older_valid_reg   <= older_valid_next;
            older_reg         <= older_next;
            newer_valid_reg   <= newer_valid_next;
            newer_reg         <= newer_next;
        end
    end

endmodule

[rtl/core/plia_out_reg.sv]
module plia_out_reg
    import plia_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    advance,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign advance = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
            valid_next = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[rtl/core/ply_list_index_primitive_assembler.sv]
// PLY list index assembler. Bytes of a binary little-endian PLY list element
// arrive one per request on the input channel, and a byte can enter on every
// clock while in_ready is high. Each byte is captured in an input register
// at the accepting edge and decoded by one pass of parse logic, which waits
// while the result register is full and out_ready is low. Any result is
// stored in the result register and drives out_valid. The input side keeps
// accepting while a result waits; in_ready drops only when the input register
// still holds a byte while the result register is full and out_ready is low.
// Each list entry is a count (1, 2 or 4 bytes) and that many indices
// of the configured width. Face mode (strip_mode = 0) returns each index;
// strip mode forms triangles from a two-index window that is cleared at the
// start of each entry and on an all-ones restart index. After entry_total
// entries a result marked element_done is returned (kind 2 if it carries
// no primitive); later bytes are dropped until entry_total is written again,
// which also restarts parsing. Write configuration only while idle.
module ply_list_index_primitive_assembler
    import plia_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CountWidth-1:0] cfg_data,
    // byte input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ByteWidth-1:0]  data_byte,
    // results
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            result_kind,
    output logic [IndexWidth-1:0] index_first,
    output logic [IndexWidth-1:0] index_second,
    output logic [IndexWidth-1:0] index_third,
    output logic                  entry_end,
    output logic                  element_done
);

    cfg_t                 cfg;
    result_t              res;
    result_t              out_res;
    logic                 res_valid;
    logic                 advance;
    logic                 step;

    logic                 in_valid_reg, in_valid_next;
    logic [ByteWidth-1:0] byte_reg;

    plia_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // a held byte is parsed once the result register can take its result
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= data_byte;
    end

    plia_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .byte_in   (byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    plia_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .advance   (advance),
        .out_res   (out_res)
    );

    assign result_kind  = out_res.kind;
    assign index_first  = out_res.first;
    assign index_second = out_res.second;
    assign index_third  = out_res.third;
    assign entry_end    = out_res.entry_end;
    assign element_done = out_res.element_done;

endmodule
